>>> hw/rtl/tssc_pkg.sv
// ---------------------------------------------------------------------------
// tssc_pkg
// Types, codes and small tables for the transport stream slice-type counter.
// ---------------------------------------------------------------------------
`default_nettype none

package tssc_pkg;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [7:0]  PACKET_BYTES     = 8'd188;
  localparam logic [7:0]  LAST_BYTE        = 8'd187;
  localparam logic [7:0]  PID_BYTE         = 8'd2;
  localparam logic [7:0]  FIRST_SCAN_BYTE  = 8'd7;
  localparam int          TAIL_CHECKS      = 184 - 180;
  localparam logic [13:0] PID_ALL          = 14'h2000;
  localparam logic [13:0] FILTER_RESET     = 14'h2000;
  localparam logic [6:0]  SPACE_CHAR       = 7'd32;
  localparam logic [3:0]  NUM_TYPES        = 4'd10;
  localparam logic [23:0] SYNC_PREFIX      = 24'h000001;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

  // count classes
  localparam logic [2:0] CLS_P  = 3'd0;
  localparam logic [2:0] CLS_B  = 3'd1;
  localparam logic [2:0] CLS_I  = 3'd2;
  localparam logic [2:0] CLS_SP = 3'd3;
  localparam logic [2:0] CLS_SI = 3'd4;
  localparam int         NUM_CLASSES = 5;

  localparam logic REG_FILTER = 1'b0;

  typedef enum logic [1:0] {
    JOB_EVENT,
    JOB_READ,
    JOB_CLEAR
  } job_kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       packet_start;
    logic [9:0] history_index;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  slice_kind;
    logic [6:0]  slice_letter;
    logic [31:0] count_i;
    logic [31:0] count_p;
    logic [31:0] count_b;
    logic [31:0] count_si;
    logic [31:0] count_sp;
    logic [6:0]  history_char;
    logic        last_of_run;
  } rsp_t;

  function automatic logic [2:0] type_class(input logic [3:0] st);
    logic [3:0] r;
    r = (st >= 4'd5) ? st - 4'd5 : st;
    return r[2:0];
  endfunction

  function automatic logic [6:0] class_letter(input logic [2:0] cls);
    logic [6:0] l;
    case (cls)
      CLS_P:   l = 7'd80;   // P
      CLS_B:   l = 7'd66;   // B
      CLS_I:   l = 7'd73;   // I
      CLS_SP:  l = 7'd112;  // p
      default: l = 7'd105;  // i
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tssc_slice_decode.sv
// ---------------------------------------------------------------------------
// tssc_slice_decode
// Checks one eight-byte view for a slice NAL start and decodes the slice type.
// ---------------------------------------------------------------------------
`default_nettype none

module tssc_slice_decode (
  input  wire logic [63:0] view,
  output logic             hit,
  output logic [3:0]       stype
);

  logic [7:0]  nal;
  logic [4:0]  nal_type;
  logic [31:0] word;
  logic [4:0]  n1;
  logic        found;
  logic [63:0] shifted;
  logic [6:0]  t;
  logic        have;
  logic        nal_ok;

  assign nal      = view[39:32];
  assign nal_type = nal[4:0];
  assign word     = view[31:0];

  // leading zeros of the first exp-golomb code
  always_comb begin
    n1    = '0;
    found = 1'b0;
    for (int b = 31; b >= 0; b--) begin
      if (!found && word[b]) begin
        n1    = 5'(31 - b);
        found = 1'b1;
      end
    end
  end

  assign shifted = {word, 32'd0} << {n1, 1'b1};
  assign t       = shifted[63:57];

  always_comb begin
    have  = 1'b1;
    stype = '0;
    if (t[6]) begin
      stype = 4'd0;
    end else if (t[5]) begin
      stype = 4'd1 + {3'd0, t[4]};
    end else if (t[4]) begin
      stype = 4'd3 + {2'd0, t[3:2]};
    end else if (t[3]) begin
      stype = 4'd7 + {1'b0, t[2:0]};
    end else begin
      have = 1'b0;
    end
  end

  assign nal_ok = !nal[7] && (nal_type == 5'd1 || nal_type == 5'd2 ||
                              nal_type == 5'd5 || nal_type == 5'd19);

  assign hit = (view[63:40] == tssc_pkg::SYNC_PREFIX) && nal_ok && (word != 32'd0) &&
               have && (stype < tssc_pkg::NUM_TYPES);

endmodule

`default_nettype wire

>>> hw/rtl/tssc_history_ram.sv
// ---------------------------------------------------------------------------
// tssc_history_ram
// History letter store: one write port, one registered read port; an entry
// not written since the last clear reads as a space.
// ---------------------------------------------------------------------------
`default_nettype none

module tssc_history_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [6:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  input  wire logic          rfilled,
  output logic [6:0]         rchar
);

  logic [6:0] mem [DEPTH];
  logic [6:0] mem_q;
  logic       valid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (re) begin
      valid_q <= rfilled;
    end
  end

  assign rchar = valid_q ? mem_q : tssc_pkg::SPACE_CHAR;

endmodule

`default_nettype wire

>>> hw/rtl/ts_slice_type_counter.sv
// ---------------------------------------------------------------------------
// ts_slice_type_counter
// Follows one PID of a transport stream, finds H.264 slice headers, counts
// slice types and keeps a ring of slice letters that can be read back.
// ---------------------------------------------------------------------------
// path: a slice event goes from the job stage to the output register, a history
//   answer from the job stage through the RAM read register to the output register
// throughput: one request per cycle unless the job stage is busy; a byte that
//   ends two slices holds it until both results pass the single output register
// reset: clears packet tracking, counts, write pointer and the
//   history fill count, so the ring reads as spaces with no clearing pass
`default_nettype none

module ts_slice_type_counter #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire tssc_pkg::req_t       req_data,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output tssc_pkg::rsp_t            rsp_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int NCHK    = tssc_pkg::TAIL_CHECKS + 1;

  // index modulo the ring depth by compare and subtract of shifted depths
  function automatic logic [HIST_AW-1:0] ring_index(input logic [9:0] idx);
    logic [10:0] r;
    r = {1'b0, idx};
    for (int k = 9; k >= 0; k--) begin
      if ((HISTORY_DEPTH << k) <= 1023 && r >= 11'(HISTORY_DEPTH << k)) begin
        r = r - 11'(HISTORY_DEPTH << k);
      end
    end
    return HIST_AW'(r);
  endfunction

  // configuration
  logic [13:0] packet_id_filter;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tssc_pkg::REG_FILTER) ? {18'd0, packet_id_filter} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_id_filter <= tssc_pkg::FILTER_RESET;
    end else if (psel && penable && pwrite && paddr[2] == tssc_pkg::REG_FILTER) begin
      packet_id_filter <= pwdata[13:0];
    end
  end

  // packet tracking
  logic [7:0]  byte_position;
  logic [63:0] byte_window;
  logic        packet_selected;
  logic [7:0]  pos_eff;
  logic        byte_ok;
  logic [63:0] win_next;
  logic [12:0] pid;
  logic        sel_next;
  logic        req_fire;

  assign req_fire = req_valid && req_ready;
  assign pos_eff  = req_data.packet_start ? 8'd0 : byte_position;
  assign byte_ok  = (req_data.mode == tssc_pkg::MODE_BYTE) && (pos_eff < tssc_pkg::PACKET_BYTES);
  assign win_next = {byte_window[55:0], req_data.data_byte};
  assign pid      = {byte_window[4:0], req_data.data_byte};
  assign sel_next = (packet_id_filter == tssc_pkg::PID_ALL) ||
                    ({1'b0, pid} == packet_id_filter);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      byte_window     <= '0;
      packet_selected <= 1'b0;
    end else if (req_fire && byte_ok) begin
      byte_window   <= win_next;
      byte_position <= pos_eff + 8'd1;
      if (pos_eff == tssc_pkg::PID_BYTE) begin
        packet_selected <= sel_next;
      end
    end
  end

  // slice checks: the newest offset, plus the tail offsets on the last byte
  logic [NCHK-1:0] chk_hit;
  logic [NCHK-1:0] chk_en;
  logic [3:0]      chk_type [NCHK];

  for (genvar s = 0; s < NCHK; s++) begin : g_chk
    tssc_slice_decode u_dec (
      .view  (win_next << (8 * s)),
      .hit   (chk_hit[s]),
      .stype (chk_type[s])
    );
    if (s == 0) begin : g_main
      assign chk_en[s] = packet_selected && (pos_eff >= tssc_pkg::FIRST_SCAN_BYTE);
    end else begin : g_tail
      assign chk_en[s] = packet_selected && (pos_eff == tssc_pkg::LAST_BYTE);
    end
  end

  logic [1:0] ev_cnt;
  logic [3:0] ev_type0;
  logic [3:0] ev_type1;

  always_comb begin
    ev_cnt   = '0;
    ev_type0 = '0;
    ev_type1 = '0;
    for (int s = 0; s < NCHK; s++) begin
      if (chk_en[s] && chk_hit[s]) begin
        if (ev_cnt == 2'd0) begin
          ev_type0 = chk_type[s];
          ev_cnt   = 2'd1;
        end else if (ev_cnt == 2'd1) begin
          ev_type1 = chk_type[s];
          ev_cnt   = 2'd2;
        end
      end
    end
  end

  // job stage
  logic                   s1_valid;
  tssc_pkg::job_kind_t    s1_kind;
  logic                   s1_two;
  logic                   s1_phase;
  logic [3:0]             s1_type0;
  logic [3:0]             s1_type1;
  logic [HIST_AW-1:0]     s1_idx;
  logic                   s1_step;
  logic                   s1_done;
  logic                   job_load;
  tssc_pkg::job_kind_t    job_kind;

  // read response stage
  logic                   r_valid;
  logic                   out_free;

  // state
  logic [31:0]            counts [tssc_pkg::NUM_CLASSES];
  logic [HIST_AW-1:0]     wp;
  logic [HIST_AW:0]       fill;
  logic [3:0]             cur_type;
  logic [2:0]             cur_cls;
  logic [31:0]            cnt_next;
  logic [HIST_AW:0]       rsum;
  logic [HIST_AW-1:0]     raddr;
  logic [HIST_AW+1:0]     fsum;
  logic                   rd_filled;
  logic [6:0]             rchar;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_done;

  always_comb begin
    job_load = 1'b0;
    job_kind = tssc_pkg::JOB_EVENT;
    unique case (req_data.mode)
      tssc_pkg::MODE_BYTE: begin
        job_load = byte_ok && (ev_cnt != 2'd0);
      end
      tssc_pkg::MODE_READ: begin
        job_load = 1'b1;
        job_kind = tssc_pkg::JOB_READ;
      end
      tssc_pkg::MODE_CLEAR: begin
        job_load = 1'b1;
        job_kind = tssc_pkg::JOB_CLEAR;
      end
      default: begin
        job_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    s1_step = 1'b0;
    s1_done = 1'b0;
    if (s1_valid) begin
      unique case (s1_kind)
        tssc_pkg::JOB_EVENT: begin
          s1_step = out_free && !r_valid;
          s1_done = s1_step && (s1_phase || !s1_two);
        end
        default: begin
          s1_step = !r_valid || out_free;
          s1_done = s1_step;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else begin
      if (req_fire && job_load) begin
        s1_valid <= 1'b1;
        s1_phase <= 1'b0;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (s1_step) begin
        s1_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && job_load) begin
      s1_kind  <= job_kind;
      s1_two   <= (ev_cnt == 2'd2);
      s1_type0 <= ev_type0;
      s1_type1 <= ev_type1;
      s1_idx   <= ring_index(req_data.history_index);
    end
  end

  logic ev_step;
  logic rd_step;
  logic clr_step;

  assign ev_step  = s1_step && (s1_kind == tssc_pkg::JOB_EVENT);
  assign rd_step  = s1_step && (s1_kind == tssc_pkg::JOB_READ);
  assign clr_step = s1_step && (s1_kind == tssc_pkg::JOB_CLEAR);

  assign cur_type = s1_phase ? s1_type1 : s1_type0;
  assign cur_cls  = tssc_pkg::type_class(cur_type);
  assign cnt_next = (counts[cur_cls] == tssc_pkg::COUNT_MAX) ? counts[cur_cls]
                                                             : counts[cur_cls] + 32'd1;

  assign rsum  = {1'b0, wp} + {1'b0, s1_idx};
  assign raddr = (rsum >= (HIST_AW + 1)'(HISTORY_DEPTH)) ?
                 HIST_AW'(rsum - (HIST_AW + 1)'(HISTORY_DEPTH)) : rsum[HIST_AW-1:0];

  // the last fill writes sit just behind wp, so only indexes near the top hold letters
  assign fsum      = {2'b00, s1_idx} + {1'b0, fill};
  assign rd_filled = (fsum >= (HIST_AW + 2)'(HISTORY_DEPTH));

  // pair counts kept directly: a saturating sum of two saturating counts
  always_ff @(posedge clk) begin
    if (rst || clr_step) begin
      for (int c = 0; c < tssc_pkg::NUM_CLASSES; c++) begin
        counts[c] <= '0;
      end
    end else if (ev_step) begin
      counts[cur_cls] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (ev_step) begin
      wp <= (wp == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp + HIST_AW'(1);
    end
  end

  // letters written since the last clear, saturating at the ring depth
  always_ff @(posedge clk) begin
    if (rst || clr_step) begin
      fill <= '0;
    end else if (ev_step && fill != (HIST_AW + 1)'(HISTORY_DEPTH)) begin
      fill <= fill + (HIST_AW + 1)'(1);
    end
  end

  tssc_history_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (HIST_AW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .we      (ev_step),
    .waddr   (wp),
    .wdata   (tssc_pkg::class_letter(cur_cls)),
    .re      (rd_step),
    .raddr   (raddr),
    .rfilled (rd_filled),
    .rchar   (rchar)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (rd_step) begin
      r_valid <= 1'b1;
    end else if (out_free) begin
      r_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((r_valid && out_free) || ev_step) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_valid && out_free) begin
      rsp_data.result_kind  <= 1'b1;
      rsp_data.slice_kind   <= '0;
      rsp_data.slice_letter <= tssc_pkg::SPACE_CHAR;
      rsp_data.count_i      <= counts[tssc_pkg::CLS_I];
      rsp_data.count_p      <= counts[tssc_pkg::CLS_P];
      rsp_data.count_b      <= counts[tssc_pkg::CLS_B];
      rsp_data.count_si     <= counts[tssc_pkg::CLS_SI];
      rsp_data.count_sp     <= counts[tssc_pkg::CLS_SP];
      rsp_data.history_char <= rchar;
      rsp_data.last_of_run  <= 1'b1;
    end else if (ev_step) begin
      rsp_data.result_kind  <= 1'b0;
      rsp_data.slice_kind   <= cur_type;
      rsp_data.slice_letter <= tssc_pkg::class_letter(cur_cls);
      rsp_data.count_i      <= (cur_cls == tssc_pkg::CLS_I)  ? cnt_next
                                                             : counts[tssc_pkg::CLS_I];
      rsp_data.count_p      <= (cur_cls == tssc_pkg::CLS_P)  ? cnt_next
                                                             : counts[tssc_pkg::CLS_P];
      rsp_data.count_b      <= (cur_cls == tssc_pkg::CLS_B)  ? cnt_next
                                                             : counts[tssc_pkg::CLS_B];
      rsp_data.count_si     <= (cur_cls == tssc_pkg::CLS_SI) ? cnt_next
                                                             : counts[tssc_pkg::CLS_SI];
      rsp_data.count_sp     <= (cur_cls == tssc_pkg::CLS_SP) ? cnt_next
                                                             : counts[tssc_pkg::CLS_SP];
      rsp_data.history_char <= tssc_pkg::SPACE_CHAR;
      rsp_data.last_of_run  <= s1_phase || !s1_two;
    end
  end

  // a pending history answer is never overtaken by a slice event
  a_read_before_event: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> !ev_step)
    else $error("slice event issued while a history answer is pending");

  // the write pointer stays inside the ring
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp <= HIST_AW'(HISTORY_DEPTH - 1))
    else $error("history write pointer out of range");

  // a second event phase only exists for a two-event job
  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_phase) |-> (s1_kind == tssc_pkg::JOB_EVENT && s1_two))
    else $error("job stage in second phase without a second event");

  // a blocked history answer stays pending
  a_read_held: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !out_free) |=> r_valid)
    else $error("history answer dropped");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Bench for the slice-type counter: streams transport packets carrying H.264
// slice headers, reads the history ring back and checks every result against
// a behavioral model of the counter kept in the bench.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int HIST = 64;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  tssc_pkg::req_t req_data = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  tssc_pkg::rsp_t rsp_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  ts_slice_type_counter #(.HISTORY_DEPTH(HIST)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [13:0] pid_filter;
  logic [7:0]  pkt_pos;
  logic [63:0] win;
  logic        pkt_sel;
  logic [31:0] slice_cnt [10];
  logic [6:0]  hist_ring [HIST];
  int          hist_wr;

  tssc_pkg::rsp_t expected_rsp [$];
  int             mismatches = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic tssc_pkg::rsp_t make_rsp(logic kind, logic [3:0] sk, logic [6:0] let_c,
                                              logic [6:0] hc);
    tssc_pkg::rsp_t r;
    r.result_kind = kind;
    r.slice_kind = sk;
    r.slice_letter = let_c;
    r.count_i = sat_add(slice_cnt[2], slice_cnt[7]);
    r.count_p = sat_add(slice_cnt[0], slice_cnt[5]);
    r.count_b = sat_add(slice_cnt[1], slice_cnt[6]);
    r.count_si = sat_add(slice_cnt[4], slice_cnt[9]);
    r.count_sp = sat_add(slice_cnt[3], slice_cnt[8]);
    r.history_char = hc;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // slice type from the four header bytes, 10 or more when none is counted
  function automatic int ue_type_code(logic [31:0] w);
    int n1, n2, p, v;
    if (w == 0) return 10;
    n1 = 0;
    while (!w[31 - n1]) n1++;
    p = 2 * n1 + 1;              // bits consumed by first code
    n2 = 0;
    while (p + n2 < 32 && !w[31 - p - n2]) n2++;
    if (p + n2 >= 32) return 10;
    if (n2 > 3) return 10;
    v = 0;
    for (int i = 0; i <= 2 * n2; i++)
      v = (v << 1) | ((p + i < 32) ? w[31 - p - i] : 1'b0);
    return v - 1;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < 10; i++) slice_cnt[i] = '0;
    for (int i = 0; i < HIST; i++) hist_ring[i] = tssc_pkg::SPACE_CHAR;
  endfunction

  function automatic int try_slice(logic [63:0] v, int k);
    logic [7:0] nal;
    int st;
    logic [6:0] l;
    nal = v[39:32];
    if (v[63:40] != tssc_pkg::SYNC_PREFIX || nal[7]) return 0;
    if (!(nal[4:0] inside {5'd1, 5'd2, 5'd5, 5'd19})) return 0;
    st = ue_type_code(v[31:0]);
    if (st >= 10 || k >= 2) return 0;
    if (slice_cnt[st] != 32'hFFFF_FFFF) slice_cnt[st]++;
    case (st % 5)
      0: l = 7'd80;
      1: l = 7'd66;
      2: l = 7'd73;
      3: l = 7'd112;
      default: l = 7'd105;
    endcase
    hist_ring[hist_wr] = l;
    hist_wr = (hist_wr + 1) % HIST;
    expected_rsp.push_back(make_rsp(1'b0, st[3:0], l, tssc_pkg::SPACE_CHAR));
    return 1;
  endfunction

  function automatic void predict_request(tssc_pkg::req_t q);
    int n, pos, at;
    tssc_pkg::rsp_t r;
    n = 0;
    if (q.mode == tssc_pkg::MODE_BYTE) begin
      pos = q.packet_start ? 0 : pkt_pos;
      if (pos < 188) begin
        win = {win[55:0], q.data_byte};
        pkt_pos = 8'(pos + 1);
        if (pos == 2)
          pkt_sel = (pid_filter == tssc_pkg::PID_ALL) ||
                    ({1'b0, win[12:8], win[7:0]} == pid_filter);
        if (pkt_sel && pos >= 7) begin
          n += try_slice(win, n);
          if (pos == 187)
            for (int s = 1; s <= 4; s++) n += try_slice(win << (8 * s), n);
        end
      end
    end else if (q.mode == tssc_pkg::MODE_READ) begin
      at = (hist_wr + (q.history_index % HIST)) % HIST;
      r = make_rsp(1'b1, 4'd0, tssc_pkg::SPACE_CHAR, hist_ring[at]);
      expected_rsp.push_back(r);
      n = 1;
    end else if (q.mode == tssc_pkg::MODE_CLEAR) begin
      clear_model();
    end
    if (n > 0) expected_rsp[$].last_of_run = 1'b1;
  endfunction

  // valid stays up after an accepted request unless idle cycles follow
  task automatic send_request(tssc_pkg::req_t q);
    int gap;
    gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= q;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_request(q);
  endtask

  task automatic send_byte(logic [7:0] b, logic st);
    tssc_pkg::req_t q;
    q = '0;
    q.mode = tssc_pkg::MODE_BYTE;
    q.data_byte = b;
    q.packet_start = st;
    q.history_index = 10'($urandom);
    send_request(q);
  endtask

  task automatic send_cmd(logic [1:0] m, logic [9:0] idx);
    tssc_pkg::req_t q;
    q = '0;
    q.mode = m;
    q.history_index = idx;
    q.data_byte = 8'($urandom);
    q.packet_start = 1'($urandom);
    send_request(q);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_filter(logic [13:0] v);
    wait_idle();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {18'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    pid_filter = v;
  endtask

  // packet with a given pid; slices planted at random offsets, tail too
  task automatic send_packet(logic [12:0] pid, int nslice, bit noisy);
    logic [7:0] p [188];
    int o;
    for (int i = 0; i < 188; i++) p[i] = noisy ? 8'($urandom) : 8'($urandom_range(2, 255));
    p[0] = 8'h47;
    p[1] = {3'($urandom), pid[12:8]};
    p[2] = pid[7:0];
    for (int k = 0; k < nslice; k++) begin
      o = ($urandom_range(0, 3) == 0) ? $urandom_range(176, 184) : $urandom_range(3, 184);
      p[o] = 8'h00;
      if (o + 1 < 188) p[o + 1] = 8'h00;
      if (o + 2 < 188) p[o + 2] = 8'h01;
      if (o + 3 < 188) begin
        case ($urandom_range(0, 4))
          0: p[o + 3] = 8'h01;
          1: p[o + 3] = 8'h02;
          2: p[o + 3] = 8'h05;
          3: p[o + 3] = 8'h13;
          default: p[o + 3] = 8'($urandom);
        endcase
        p[o + 3][6:5] = 2'($urandom);
      end
      for (int j = 4; j < 8; j++)
        if (o + j < 188) p[o + j] = ($urandom_range(0, 1)) ? 8'($urandom) :
                                    8'($urandom_range(0, 7)) << $urandom_range(0, 5);
    end
    for (int i = 0; i < 188; i++) send_byte(p[i], i == 0);
  endtask

  task automatic test_directed();
    // first byte after reset acts as byte 0 without packet_start
    send_byte(8'h47, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h65, 1'b0);
    send_byte(8'hB8, 1'b0);   // first_mb 0, type 2
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_cmd(tssc_pkg::MODE_READ, 10'd63);
    send_cmd(tssc_pkg::MODE_READ, 10'd1023);
    send_cmd(tssc_pkg::MODE_READ, 10'd0);
    send_cmd(tssc_pkg::MODE_UNUSED, 10'd5);
    send_cmd(tssc_pkg::MODE_CLEAR, 10'd0);
    send_cmd(tssc_pkg::MODE_READ, 10'd63);
  endtask

  task automatic test_streams();
    send_packet(13'($urandom), $urandom_range(1, 6), 1'b0);
    send_packet(13'h1FFF, 8, 1'b1);
    // long packet: bytes past the end are ignored
    for (int i = 0; i < 5; i++) send_byte(8'h00, 1'b0);
  endtask

  task automatic test_filter();
    write_filter(14'h0100);
    send_packet(13'h0100, 4, 1'b0);
    send_packet(13'h0101, 4, 1'b0);
    write_filter(14'h0000);
    send_packet(13'h0000, 4, 1'b0);
    write_filter(14'h3FFF);
    send_packet(13'h1FFF, 4, 1'b0);
    write_filter(14'h1FFF);
    send_packet(13'h1FFF, 4, 1'b0);
    write_filter(tssc_pkg::PID_ALL);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 140) begin
      case ($urandom_range(0, 9))
        0, 1: send_cmd(tssc_pkg::MODE_READ, 10'($urandom));
        2: begin
          if ($urandom_range(0, 5) == 0) send_cmd(tssc_pkg::MODE_CLEAR, '0);
          else send_cmd(2'($urandom), 10'($urandom));
        end
        default: send_byte(8'($urandom), 1'($urandom_range(0, 30) == 0));
      endcase
      sent++;
    end
    for (int i = 0; i < 70; i++) send_cmd(tssc_pkg::MODE_READ, 10'(i));
  endtask

  // receiver: random stall per result
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        rsp_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp_data);
      end else begin
        if (rsp_data !== expected_rsp[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_rsp[0], rsp_data);
        end
        void'(expected_rsp.pop_front());
      end
    end
  end

  initial begin
    pid_filter = tssc_pkg::FILTER_RESET;
    pkt_pos = '0;
    win = '0;
    pkt_sel = 1'b0;
    hist_wr = 0;
    clear_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_streams();
    test_filter();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("** ts_slice_type_counter: PASSED **");
    end else begin
      $display("** ts_slice_type_counter: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** ts_slice_type_counter: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
